>>> sv/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    localparam int NUM_STACKS   = 16;
    localparam int CAPACITY_MAX = 16;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int CAP_W   = 5;
    localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int LEVEL_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
    localparam int FILL_W  = $clog2(CAPACITY_MAX + 1);
    localparam int DEPTH   = NUM_STACKS * CAPACITY_MAX;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_PUSH   = 2'd0;
    localparam func_t FUNC_POP    = 2'd1;
    localparam func_t FUNC_POP_AT = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        func_t                     func;
        logic signed [DATA_W-1:0]  push_value;
        logic        [IDX_W-1:0]   stack_index;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pop_value;
        status_t                   status;
        logic        [IDX_W-1:0]   used_stack;
    } rsp_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   used_stack;
        logic               pop_ok;
    } op_info_t;

endpackage

`default_nettype wire

>>> sv/bounded_stack_array.sv
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the response side does not stall; the single
// plate store port (at most one read or one write per request) and one result register set this.
// Reset: all stack fill counts clear to zero and the capacity register returns to 16.
// The plate store is not cleared; the fill counts keep unwritten slots from being read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_array
    import bsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp_data
);

    logic [CAP_W-1:0]  stack_capacity_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    op_info_t          info_reg;
    op_info_t          info;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    logic              accept;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            stack_capacity_reg <= cfg_wdata;
        end
    end

    bsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req_data),
        .cap_cfg (stack_capacity_reg),
        .mem_req (mem_req),
        .info    (info)
    );

    bsa_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info;
        end
    end

    // The read data register holds while stalled, since the store is only read on acceptance.
    assign rsp_valid           = rsp_valid_reg;
    assign rsp_data.pop_value  = info_reg.pop_ok ? rd_data : '0;
    assign rsp_data.status     = info_reg.status;
    assign rsp_data.used_stack = info_reg.used_stack;

    a_no_mem_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> (!mem_req.we && !mem_req.re))
        else $error("plate store accessed without an accepted request");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("plate store read and written in the same cycle");

    a_refused_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && info.status != ST_OK) |-> (!mem_req.we && !mem_req.re))
        else $error("refused request touched the plate store");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != ST_OK) |->
            (rsp_data.pop_value == '0 && rsp_data.used_stack == '0))
        else $error("failed request returned non-zero fields");

endmodule

`default_nettype wire

>>> sv/bsa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bsa_mem
    import bsa_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_req_t          mem_req,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] plate_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            plate_mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= plate_mem[mem_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/bsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl
    import bsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire req_t              req,
    input  wire logic [CAP_W-1:0]  cap_cfg,
    output mem_req_t               mem_req,
    output op_info_t               info
);

    logic [FILL_W-1:0]  fill_reg  [NUM_STACKS];
    logic [FILL_W-1:0]  fill_next [NUM_STACKS];
    logic [FILL_W-1:0]  cap_eff;
    logic               push_found;
    logic [STACK_W-1:0] push_sel;
    logic               pop_found;
    logic [STACK_W-1:0] pop_sel;
    logic               at_ok;
    logic               is_push;
    logic               ok;
    logic [STACK_W-1:0] sel;
    logic [FILL_W-1:0]  fill_sel;
    logic [FILL_W-1:0]  fill_new;
    logic [LEVEL_W-1:0] level;

    // A capacity of zero behaves as one; anything above CAPACITY_MAX is clipped to CAPACITY_MAX.
    always_comb
    begin
        if (cap_cfg == '0)
        begin
            cap_eff = FILL_W'(1);
        end
        else if (32'(cap_cfg) > CAPACITY_MAX)
        begin
            cap_eff = FILL_W'(CAPACITY_MAX);
        end
        else
        begin
            cap_eff = FILL_W'(cap_cfg);
        end
    end

    // Leftmost stack with room, and rightmost stack holding anything.
    always_comb
    begin
        push_found = 1'b0;
        push_sel   = '0;
        pop_found  = 1'b0;
        pop_sel    = '0;
        for (int s = NUM_STACKS - 1; s >= 0; s--)
        begin
            if (fill_reg[s] < cap_eff)
            begin
                push_found = 1'b1;
                push_sel   = STACK_W'(s);
            end
        end
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            if (fill_reg[s] != '0)
            begin
                pop_found = 1'b1;
                pop_sel   = STACK_W'(s);
            end
        end
    end

    assign at_ok = (32'(req.stack_index) < NUM_STACKS) &&
                   (fill_reg[STACK_W'(req.stack_index)] != '0);

    always_comb
    begin
        is_push = 1'b0;
        unique case (req.func)
            FUNC_PUSH:
            begin
                is_push = 1'b1;
                ok      = push_found;
                sel     = push_sel;
            end
            FUNC_POP_AT:
            begin
                ok  = at_ok;
                sel = STACK_W'(req.stack_index);
            end
            default:
            begin
                ok  = pop_found;
                sel = pop_sel;
            end
        endcase
    end

    assign fill_sel = fill_reg[sel];
    assign fill_new = is_push ? fill_sel + FILL_W'(1) : fill_sel - FILL_W'(1);
    assign level    = is_push ? LEVEL_W'(fill_sel) : LEVEL_W'(fill_new);

    always_comb
    begin
        mem_req.we    = accept && ok && is_push;
        mem_req.re    = accept && ok && !is_push;
        mem_req.addr  = ADDR_W'(sel) * ADDR_W'(CAPACITY_MAX) + ADDR_W'(level);
        mem_req.wdata = req.push_value;
    end

    always_comb
    begin
        info.pop_ok = ok && !is_push;
        if (ok)
        begin
            info.status     = ST_OK;
            info.used_stack = IDX_W'(sel);
        end
        else
        begin
            info.status     = is_push ? ST_FULL : ST_EMPTY;
            info.used_stack = '0;
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            fill_next[s] = fill_reg[s];
        end
        if (accept && ok)
        begin
            fill_next[sel] = fill_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                fill_reg[s] <= fill_next[s];
            end
        end
    end

endmodule

`default_nettype wire
